[sv/assert_macros.svh]
// Assertion macros shared by the bounding box accumulator RTL.
// Expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BBACC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define BBACC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

[sv/bbacc_pkg.sv]
// Shared types and constants for the bounding box accumulator.
// No dependencies; used by the interfaces, the lanes and the merge stage.
package bbacc_pkg;

  localparam int CMD_BITS  = 3;
  localparam int GROW_BITS = 19;
  localparam int AXIS_BITS = 2;
  localparam int AREA_BITS = 43;
  localparam int VOL_BITS  = 60;
  localparam int NUM_AXES  = 3;

  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_MERGE = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_GROW  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_PTEST = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_OVLP  = 3'd5;

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

  // Pipeline controls sent from the merge stage to every lane.
  typedef struct packed {
    logic take;   // request accepted this cycle
    logic adv_b;  // stage A moves into stage B
  } bbacc_ctl_t;

  // Per-axis comparisons a lane reports against the current box.
  typedef struct packed {
    logic cur_neg;  // box low above box high on this axis
    logic pt_in;    // point within low..high
    logic ov_ok;    // other box interval touches this one
    logic oth_bad;  // other box low above its high
  } bbacc_flag_t;

endpackage

[sv/bbacc_cmd_if.sv]
// Request channel of the bounding box accumulator.
// Depends on bbacc_pkg for field widths.
interface bbacc_cmd_if #(parameter int COORD_BITS = 20);
  logic                                valid;
  logic                                ready;
  logic [bbacc_pkg::CMD_BITS-1:0]      cmd;
  logic signed [COORD_BITS-1:0]        point_x;
  logic signed [COORD_BITS-1:0]        point_y;
  logic signed [COORD_BITS-1:0]        point_z;
  logic signed [COORD_BITS-1:0]        corner_x;
  logic signed [COORD_BITS-1:0]        corner_y;
  logic signed [COORD_BITS-1:0]        corner_z;
  logic [bbacc_pkg::GROW_BITS-1:0]     grow_amount;

  modport source (
    output valid, cmd, point_x, point_y, point_z, corner_x, corner_y, corner_z,
           grow_amount,
    input  ready
  );
  modport sink (
    input  valid, cmd, point_x, point_y, point_z, corner_x, corner_y, corner_z,
           grow_amount,
    output ready
  );
endinterface

[sv/bbacc_res_if.sv]
// Result channel of the bounding box accumulator.
// Depends on bbacc_pkg for field widths.
interface bbacc_res_if #(parameter int COORD_BITS = 20);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        low_x;
  logic signed [COORD_BITS-1:0]        low_y;
  logic signed [COORD_BITS-1:0]        low_z;
  logic signed [COORD_BITS-1:0]        high_x;
  logic signed [COORD_BITS-1:0]        high_y;
  logic signed [COORD_BITS-1:0]        high_z;
  logic                                is_empty;
  logic [bbacc_pkg::AXIS_BITS-1:0]     longest_axis;
  logic [bbacc_pkg::AXIS_BITS-1:0]     shortest_axis;
  logic [bbacc_pkg::AREA_BITS-1:0]     surface_area;
  logic [bbacc_pkg::VOL_BITS-1:0]      box_volume;
  logic                                test_hit;

  modport source (
    output valid, low_x, low_y, low_z, high_x, high_y, high_z, is_empty,
           longest_axis, shortest_axis, surface_area, box_volume, test_hit,
    input  ready
  );
  modport sink (
    input  valid, low_x, low_y, low_z, high_x, high_y, high_z, is_empty,
           longest_axis, shortest_axis, surface_area, box_volume, test_hit,
    output ready
  );
endinterface

[sv/bbacc_lane.sv]
// One axis of the box: holds low/high, applies each command, reports flags.
// Depends on bbacc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbacc_lane #(
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bbacc_pkg::bbacc_ctl_t               ctl,
  input  logic [bbacc_pkg::CMD_BITS-1:0]      cmd,
  input  logic signed [COORD_BITS-1:0]        pt,
  input  logic signed [COORD_BITS-1:0]        cn,
  input  logic [bbacc_pkg::GROW_BITS-1:0]     amt,
  input  logic                                box_empty,
  output bbacc_pkg::bbacc_flag_t              flags,
  output logic signed [COORD_BITS-1:0]        b_low,
  output logic signed [COORD_BITS-1:0]        b_high,
  output logic [COORD_BITS-1:0]               b_ext,
  output logic                                b_neg
);

  localparam int SW = ((COORD_BITS > bbacc_pkg::GROW_BITS) ?
                       COORD_BITS : bbacc_pkg::GROW_BITS) + 2;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] low, high, low_next, high_next;
  logic signed [COORD_BITS-1:0] a_low, a_high;
  logic signed [SW-1:0]         amt_s, dn, up;
  logic signed [COORD_BITS:0]   diff;

  assign amt_s = $signed({{(SW-bbacc_pkg::GROW_BITS){1'b0}}, amt});
  assign dn    = SW'(low) - amt_s;
  assign up    = SW'(high) + amt_s;

  assign flags.cur_neg = low > high;
  assign flags.pt_in   = (pt >= low) && (pt <= high);
  assign flags.ov_ok   = !((high < pt) || (low > cn));
  assign flags.oth_bad = pt > cn;

  always_comb begin
    low_next  = low;
    high_next = high;
    case (cmd)
      bbacc_pkg::CMD_CLEAR: begin
        low_next  = CMAX;
        high_next = CMIN;
      end
      bbacc_pkg::CMD_ADD: begin
        if (pt < low) low_next = pt;
        if (pt > high) high_next = pt;
      end
      bbacc_pkg::CMD_MERGE: begin
        if (pt < low) low_next = pt;
        if (cn > high) high_next = cn;
      end
      bbacc_pkg::CMD_GROW: begin
        if (!box_empty) begin
          low_next  = (dn < SW'(CMIN)) ? CMIN : $signed(dn[COORD_BITS-1:0]);
          high_next = (up > SW'(CMAX)) ? CMAX : $signed(up[COORD_BITS-1:0]);
        end
      end
      default: begin
        low_next  = low;
        high_next = high;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= CMAX;
      high <= CMIN;
    end else if (ctl.take) begin
      low  <= low_next;
      high <= high_next;
    end
  end

  // Stage A holds the updated corners, stage B adds the clamped extent.
  assign diff = {a_high[COORD_BITS-1], a_high} - {a_low[COORD_BITS-1], a_low};

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      a_low  <= low_next;
      a_high <= high_next;
    end
    if (ctl.adv_b) begin
      b_low  <= a_low;
      b_high <= a_high;
      b_neg  <= a_low > a_high;
      b_ext  <= (a_high >= a_low) ? diff[COORD_BITS-1:0] : '0;
    end
  end

  `BBACC_ASSERT(clear_to_empty,
    ctl.take && cmd == bbacc_pkg::CMD_CLEAR |=> low == CMAX && high == CMIN,
    "lane: clear did not restore the empty interval")
  `BBACC_ASSERT(grow_widens,
    ctl.take && cmd == bbacc_pkg::CMD_GROW |=> low <= $past(low) && high >= $past(high),
    "lane: grow narrowed the interval")

endmodule

[sv/bbacc_merge.sv]
// Merging stage: combines lane flags into the test result and reduces the
// lane extents to axes, area and volume. Depends on bbacc_pkg, bbacc_res_if.
`include "assert_macros.svh"

module bbacc_merge #(
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bbacc_pkg::CMD_BITS-1:0]      cmd,
  input  bbacc_pkg::bbacc_flag_t              flags [bbacc_pkg::NUM_AXES],
  input  logic                                box_empty,
  output bbacc_pkg::bbacc_ctl_t               ctl,
  input  logic signed [COORD_BITS-1:0]        b_low [bbacc_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0]        b_high [bbacc_pkg::NUM_AXES],
  input  logic [COORD_BITS-1:0]               b_ext [bbacc_pkg::NUM_AXES],
  input  logic                                b_neg [bbacc_pkg::NUM_AXES],
  bbacc_res_if.source                         results
);

  localparam int EW = COORD_BITS;
  localparam int PW = 2 * EW;
  localparam int AW = (PW + 3 > bbacc_pkg::AREA_BITS) ? PW + 3 : bbacc_pkg::AREA_BITS;
  localparam int VW = (3 * EW > bbacc_pkg::VOL_BITS) ? 3 * EW : bbacc_pkg::VOL_BITS;

  logic a_v, b_v, c_v, d_v, e_v;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;
  logic hit_next, a_hit, b_hit;

  logic [PW-1:0] c_pxy, c_pxz, c_pyz;
  logic [EW-1:0] c_ez;
  logic [bbacc_pkg::AXIS_BITS-1:0] c_lng, c_sht, d_lng, d_sht, lng_next, sht_next;
  logic c_hit, c_empty, d_hit, d_empty;
  logic signed [COORD_BITS-1:0] c_low [bbacc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] c_high [bbacc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] d_low [bbacc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] d_high [bbacc_pkg::NUM_AXES];
  logic [AW-1:0] area_full;
  logic [PW-1:0] d_vlo, d_vhi;
  logic [bbacc_pkg::AREA_BITS-1:0] d_area;
  logic [VW-1:0] vol_full;

  // Handshake chain: each stage takes new data when empty or draining.
  assign e_rdy    = !e_v || results.ready;
  assign d_rdy    = !d_v || e_rdy;
  assign c_rdy    = !c_v || d_rdy;
  assign b_rdy    = !b_v || c_rdy;
  assign a_rdy    = !a_v || b_rdy;
  assign in_ready = a_rdy;
  assign ctl.take  = in_valid && a_rdy;
  assign ctl.adv_b = a_v && b_rdy;

  always_comb begin
    case (cmd)
      bbacc_pkg::CMD_PTEST:
        hit_next = flags[0].pt_in && flags[1].pt_in && flags[2].pt_in;
      bbacc_pkg::CMD_OVLP:
        hit_next = !box_empty &&
                   !(flags[0].oth_bad || flags[1].oth_bad || flags[2].oth_bad) &&
                   flags[0].ov_ok && flags[1].ov_ok && flags[2].ov_ok;
      default:
        hit_next = 1'b0;
    endcase
  end

  // Ties go to the later axis.
  always_comb begin
    if (b_ext[0] > b_ext[1] && b_ext[0] > b_ext[2]) lng_next = bbacc_pkg::AXIS_X;
    else if (b_ext[1] > b_ext[2]) lng_next = bbacc_pkg::AXIS_Y;
    else lng_next = bbacc_pkg::AXIS_Z;
    if (b_ext[0] < b_ext[1] && b_ext[0] < b_ext[2]) sht_next = bbacc_pkg::AXIS_X;
    else if (b_ext[1] < b_ext[2]) sht_next = bbacc_pkg::AXIS_Y;
    else sht_next = bbacc_pkg::AXIS_Z;
  end

  assign area_full = (AW'(c_pxy) + AW'(c_pxz) + AW'(c_pyz)) << 1;
  assign vol_full  = (VW'(d_vhi) << EW) + VW'(d_vlo);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      if (a_rdy) a_v <= in_valid;
      if (b_rdy) b_v <= a_v;
      if (c_rdy) c_v <= b_v;
      if (d_rdy) d_v <= c_v;
      if (e_rdy) e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) a_hit <= hit_next;
    if (ctl.adv_b) b_hit <= a_hit;
    if (c_rdy && b_v) begin
      c_pxy   <= PW'(b_ext[0]) * PW'(b_ext[1]);
      c_pxz   <= PW'(b_ext[0]) * PW'(b_ext[2]);
      c_pyz   <= PW'(b_ext[1]) * PW'(b_ext[2]);
      c_ez    <= b_ext[2];
      c_lng   <= lng_next;
      c_sht   <= sht_next;
      c_hit   <= b_hit;
      c_empty <= b_neg[0] || b_neg[1] || b_neg[2];
      c_low   <= b_low;
      c_high  <= b_high;
    end
    if (d_rdy && c_v) begin
      d_area  <= area_full[bbacc_pkg::AREA_BITS-1:0];
      d_vlo   <= PW'(c_pxy[EW-1:0]) * PW'(c_ez);
      d_vhi   <= PW'(c_pxy[PW-1:EW]) * PW'(c_ez);
      d_lng   <= c_lng;
      d_sht   <= c_sht;
      d_hit   <= c_hit;
      d_empty <= c_empty;
      d_low   <= c_low;
      d_high  <= c_high;
    end
    if (e_rdy && d_v) begin
      results.low_x         <= d_low[0];
      results.low_y         <= d_low[1];
      results.low_z         <= d_low[2];
      results.high_x        <= d_high[0];
      results.high_y        <= d_high[1];
      results.high_z        <= d_high[2];
      results.is_empty      <= d_empty;
      results.longest_axis  <= d_lng;
      results.shortest_axis <= d_sht;
      results.surface_area  <= d_area;
      results.box_volume    <= vol_full[bbacc_pkg::VOL_BITS-1:0];
      results.test_hit      <= d_hit;
    end
  end

  assign results.valid = e_v;

  `BBACC_NEVER(hit_on_empty,
    results.valid && results.test_hit && results.is_empty,
    "merge: test reported a hit on an empty box")
  `BBACC_NEVER(empty_has_volume,
    results.valid && results.is_empty && results.box_volume != '0,
    "merge: empty box reported nonzero volume")

endmodule

[sv/bounding_box_accumulator_unit.sv]
// Top level of the bounding box accumulator: three axis lanes and a merge stage.
// Depends on bbacc_pkg, bbacc_cmd_if, bbacc_res_if, bbacc_lane, bbacc_merge.
//
// Usage:
//   cmds carries one request per handshake: a command (clear, add point,
//   merge box, grow faces, point test, overlap test) with a point or low
//   corner, a high corner and a grow amount. results returns exactly one
//   item per request: box corners after the command, empty flag, longest
//   and shortest axis, surface area, volume and the test outcome.
//   An accepted request passes lane stages A and B and merge registers C
//   and D, is registered on results and is taken when the receiver is ready.
//   Throughput: one request per cycle while results is not stalled. The box
//   update is a registered loop inside each lane; area and volume follow in
//   a pipeline of registered multiplies behind it, the volume split in two
//   partial products.
//   Reset (rst, synchronous) sets the box to empty (low at the largest,
//   high at the smallest coordinate) and drops every request in flight.
//   When the receiver stalls, each stage holds its data; cmds.ready stays
//   high while some stage is still free, so up to five requests can be in
//   flight before cmds.ready drops.
module bounding_box_accumulator_unit #(
  parameter int COORD_BITS = 20
) (
  input  logic         clk,
  input  logic         rst,
  bbacc_cmd_if.sink    cmds,
  bbacc_res_if.source  results
);

  localparam int NA = bbacc_pkg::NUM_AXES;

  bbacc_pkg::bbacc_ctl_t  ctl;
  bbacc_pkg::bbacc_flag_t flags [NA];
  logic                   box_empty;

  logic signed [COORD_BITS-1:0] pt [NA];
  logic signed [COORD_BITS-1:0] cn [NA];
  logic signed [COORD_BITS-1:0] b_low [NA];
  logic signed [COORD_BITS-1:0] b_high [NA];
  logic [COORD_BITS-1:0]        b_ext [NA];
  logic                         b_neg [NA];

  // Route the request coordinates to their axis lanes.
  assign pt[0] = cmds.point_x;
  assign pt[1] = cmds.point_y;
  assign pt[2] = cmds.point_z;
  assign cn[0] = cmds.corner_x;
  assign cn[1] = cmds.corner_y;
  assign cn[2] = cmds.corner_z;

  // Box is empty when any axis has low above high; grow and overlap use it.
  assign box_empty = flags[0].cur_neg || flags[1].cur_neg || flags[2].cur_neg;

  for (genvar i = 0; i < NA; i++) begin : g_lane
    bbacc_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .cmd       (cmds.cmd),
      .pt        (pt[i]),
      .cn        (cn[i]),
      .amt       (cmds.grow_amount),
      .box_empty (box_empty),
      .flags     (flags[i]),
      .b_low     (b_low[i]),
      .b_high    (b_high[i]),
      .b_ext     (b_ext[i]),
      .b_neg     (b_neg[i])
    );
  end

  // Merge the lanes: test outcome, axis ranking, area, volume, output register.
  bbacc_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmds.valid),
    .in_ready  (cmds.ready),
    .cmd       (cmds.cmd),
    .flags     (flags),
    .box_empty (box_empty),
    .ctl       (ctl),
    .b_low     (b_low),
    .b_high    (b_high),
    .b_ext     (b_ext),
    .b_neg     (b_neg),
    .results   (results)
  );

endmodule
